FILE: rtl/core/kway_merge_min_heap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the k-way merge min-heap.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_MIN_HEAP_ASSERT_SVH
`define KWAY_MERGE_MIN_HEAP_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, so must the consequent.
`define KWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent follows.
`define KWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, codes and the entry order for the k-way merge min-heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  // Default heap capacity, one entry per source stream.
  localparam int DEF_NUM_STREAMS = 16;

  // Field widths.
  localparam int KEY_W   = 32;
  localparam int STRM_W  = 4;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  // Stream bus widths, padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Bit positions inside the output data word.
  localparam int OUT_STRM_LSB = KEY_W;
  localparam int OUT_FILL_LSB = KEY_W + STRM_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // One heap entry: stream index above the key.
  typedef struct packed {
    logic [STRM_W-1:0]       stream;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  // Write request into the heap store.
  typedef struct packed {
    logic   en;
    entry_t data;
  } kwm_wr_t;

  // Heap order: signed key first, then lower stream index first.
  function automatic logic entry_less(entry_t a, entry_t b);
    if (a.key != b.key) begin
      return $signed(a.key) < $signed(b.key);
    end
    return a.stream < b.stream;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kwm_store.sv
// ----------------------------------------------------------------------------
// kwm_store
// Heap entry memory: one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_store import kwm_pkg::*; #(
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire kwm_wr_t       wr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] rd_a_addr,
  input  wire logic [AW-1:0] rd_b_addr,
  output entry_t             rd_a,
  output entry_t             rd_b
);

  localparam int DEPTH = 1 << AW;

  entry_t mem [DEPTH];
  entry_t rd_a_r;
  entry_t rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Two read ports, data registered.
  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

FILE: rtl/core/kway_merge_min_heap.sv
// ----------------------------------------------------------------------------
// kway_merge_min_heap
// Min-heap of (key, stream) entries for merging sorted streams.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and answers each with exactly one
// result beat. Insert walks the new entry up from the bottom of the heap, pop
// and replace walk the refilled root down; each level is made of one
// registered read of the parent or of both children from the dual-read
// entry memory, a compare, and one write of the moved entry. A pop or
// replace first reads the root and the last entry, then walks down. A
// request that meets a full or empty heap or carries the unused code skips
// the walk and goes straight to the result. A finished result waits in the
// output register while the next request beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module kway_merge_min_heap import kwm_pkg::*; #(
  parameter int NUM_STREAMS = DEF_NUM_STREAMS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // key_value[31:0], stream_index[35:32]
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type[1:0]
  // Result channel.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // min_key[31:0], min_stream[35:32],
                                                 // fill_level[40:36]
  output logic [STAT_W-1:0]          out_tuser   // status[1:0]
);

  localparam int AW = (NUM_STREAMS > 2) ? $clog2(NUM_STREAMS) : 1;
  localparam int CW = $clog2(NUM_STREAMS + 1);
  localparam int XW = AW + 2;

  localparam logic [CW-1:0] CNT_FULL = CW'(NUM_STREAMS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     hole_r, hole_nxt;
  logic              pop_r, pop_nxt;
  entry_t            item_r, item_nxt;
  entry_t            min_r, min_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]     out_user_r;

  entry_t        in_e;
  logic          accept;
  logic          load_out;
  kwm_wr_t       wr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  entry_t        rd_a, rd_b;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] left_x, right_x;
  logic [XW-1:0] nleft_x, nright_x;
  logic          use_right;
  entry_t        child_e;
  logic [XW-1:0] child_x;
  logic [CW-1:0] last_idx;
  logic [FILL_W+CW-1:0] fill_x;

  // Request beat unpacking.
  assign in_e.key    = in_tdata[KEY_W-1:0];
  assign in_e.stream = in_tdata[KEY_W +: STRM_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Child indexes of the current hole, and the better child.
  assign cnt_x     = XW'(count_r);
  assign left_x    = {1'b0, hole_r, 1'b1};
  assign right_x   = left_x + XW'(1);
  assign use_right = (right_x < cnt_x) && entry_less(rd_b, rd_a);
  assign child_e   = use_right ? rd_b : rd_a;
  assign child_x   = use_right ? right_x : left_x;
  assign last_idx  = count_r - CW'(1);

  // Sequencer: one heap level per cycle.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    hole_nxt   = hole_r;
    pop_nxt    = pop_r;
    item_nxt   = item_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    wr.en      = 1'b0;
    wr.data    = item_r;
    wr_addr    = hole_r;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt   = in_e;
          min_nxt    = '0;
          status_nxt = ST_OK;
          pop_nxt    = (in_tuser == REQ_POP);
          case (in_tuser)
            REQ_INSERT: begin
              if (count_r == CNT_FULL) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                hole_nxt  = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP;
              end
            end
            REQ_POP, REQ_REPLACE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_UP: begin
        // rd_a holds the parent of the hole.
        wr.en = 1'b1;
        if ((hole_r != '0) && entry_less(item_r, rd_a)) begin
          wr.data  = rd_a;
          hole_nxt = (hole_r - AW'(1)) >> 1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        // rd_a holds the root, rd_b the last entry.
        min_nxt  = rd_a;
        hole_nxt = '0;
        if (pop_r) begin
          item_nxt  = rd_b;
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DN;
      end
      S_DN: begin
        // rd_a and rd_b hold the two children of the hole.
        wr.en = 1'b1;
        if ((left_x < cnt_x) && entry_less(child_e, item_r)) begin
          wr.data  = child_e;
          hole_nxt = child_x[AW-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Read addresses follow the level that the next cycle works on.
  assign nleft_x  = {1'b0, hole_nxt, 1'b1};
  assign nright_x = nleft_x + XW'(1);

  always_comb begin
    case (state_nxt)
      S_UP: begin
        rd_a_addr = (hole_nxt - AW'(1)) >> 1;
        rd_b_addr = rd_a_addr;
      end
      S_DN: begin
        rd_a_addr = nleft_x[AW-1:0];
        rd_b_addr = nright_x[AW-1:0];
      end
      default: begin
        rd_a_addr = '0;
        rd_b_addr = last_idx[AW-1:0];
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    hole_r   <= hole_nxt;
    pop_r    <= pop_nxt;
    item_r   <= item_nxt;
    min_r    <= min_nxt;
    status_r <= status_nxt;
  end

  // Output register.
  assign fill_x = {{FILL_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{(OUT_DATA_W - KEY_W - STRM_W - FILL_W){1'b0}},
                     fill_x[FILL_W-1:0], min_r.stream, min_r.key};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Heap entry memory.
  kwm_store #(
    .AW (AW)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

endmodule

`default_nettype wire

FILE: rtl/core/kwm_checker.sv
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks for the k-way merge min-heap, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "kway_merge_min_heap_assert.svh"

module kwm_checker import kwm_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_DATA_W-1:0]  in_tdata,   // key_value[31:0], stream_index[35:32]
  input wire logic [REQ_W-1:0]      in_tuser,   // req_type[1:0]
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,  // min_key[31:0], min_stream[35:32],
                                                // fill_level[40:36]
  input wire logic [STAT_W-1:0]     out_tuser   // status[1:0]
);

  // A stalled result beat holds its payload.
  `KWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // Only defined status codes leave the block.
  `KWM_ASSERT_IMP(a_status_code, clk, rst_n, out_tvalid,
    out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL, "undefined status code")

  // An empty heap reports no entry and a fill level of zero.
  `KWM_ASSERT_IMP(a_empty_result, clk, rst_n, out_tvalid && out_tuser == ST_EMPTY,
    out_tdata[OUT_FILL_LSB +: FILL_W] == '0 && out_tdata[OUT_FILL_LSB-1:0] == '0, "empty status with data")

  // Requests are worked one at a time: no beat directly after an accepted one.
  `KWM_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready,
    !in_tready, "request accepted while the previous one is in progress")

endmodule

bind kway_merge_min_heap kwm_checker u_kwm_checker (.*);

`default_nettype wire
